/* rtl/rgbhsv_pkg.sv */
// Package with the types, constants and divider step shared by the RGB to HSV core.
package rgbhsv_pkg;

    localparam int unsigned CHAN_W = 8;
    localparam int unsigned HUE_W = 15;

    // Hue in 1/64 degree: one sextant is 3840 and the full circle is 23040.
    localparam logic [HUE_W-1:0] HUE_SEXTANT = 15'd3840;
    localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_BLUE_BASE = 15'd15360;
    localparam logic [HUE_W-1:0] HUE_FULL = 15'd23040;

    // The hue quotient is at most 3840, so 12 bits; the dividend is 3840 * |diff|.
    localparam int unsigned HUE_QBITS = 12;
    localparam int unsigned HUE_NUM_W = 20;
    // Saturation quotient 255 * delta / max is at most 255.
    localparam int unsigned SAT_QBITS = 8;
    localparam int unsigned SAT_NUM_W = 16;

    localparam int unsigned BITS_PER_STAGE = 2;
    localparam int unsigned DIV_STAGES = HUE_QBITS / BITS_PER_STAGE;

    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2
    } max_sel_t;

    typedef struct packed {
        logic                 grey;
        max_sel_t             sel;
        logic                 neg;
        logic [CHAN_W-1:0]    mx;
        logic [CHAN_W-1:0]    delta;
        logic [HUE_NUM_W-1:0] hrem;
        logic [HUE_QBITS-1:0] hquo;
        logic [SAT_NUM_W-1:0] srem;
        logic [SAT_QBITS-1:0] squo;
    } div_word_t;

    // Two restoring division steps for the hue quotient, and for the saturation
    // quotient while it still has bits left.
    function automatic div_word_t div_stage(input div_word_t w, input int unsigned stage);
        div_word_t            o;
        int unsigned          step;
        logic [HUE_NUM_W-1:0] hd;
        logic [SAT_NUM_W-1:0] sd;
        o = w;
        for (int unsigned j = 0; j < BITS_PER_STAGE; j++) begin
            step = stage * BITS_PER_STAGE + j;
            hd = HUE_NUM_W'(o.delta) << (HUE_QBITS - 1 - step);
            if (o.hrem >= hd) begin
                o.hrem = o.hrem - hd;
                o.hquo = {o.hquo[HUE_QBITS-2:0], 1'b1};
            end
            else begin
                o.hquo = {o.hquo[HUE_QBITS-2:0], 1'b0};
            end
            if (step < SAT_QBITS) begin
                sd = SAT_NUM_W'(o.mx) << (SAT_QBITS - 1 - step);
                if (o.srem >= sd) begin
                    o.srem = o.srem - sd;
                    o.squo = {o.squo[SAT_QBITS-2:0], 1'b1};
                end
                else begin
                    o.squo = {o.squo[SAT_QBITS-2:0], 1'b0};
                end
            end
        end
        return o;
    endfunction

endpackage

/* rtl/rgb_to_hsv_converter_core.sv */
// RGB to HSV pixel converter core: a nine-stage pipeline with pipelined dividers.
//
//   channel  valid          stall          words
//   pixel    pixel_valid    pixel_stall    red_in, green_in, blue_in
//   result   result_valid   result_stall   hue_out, saturation_out, value_out
//
// One word enters per cycle while pixel_stall is low.
// The hue divider resolves two quotient bits per stage, the saturation divider too until its eight bits are done.
// Reset clears the valid bits of all stages; no clearing pass is needed.
// A stall on a waiting result freezes the whole pipeline and raises pixel_stall
// in the same cycle; nothing is dropped or repeated.
module rgb_to_hsv_converter_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pixel_valid,
    output logic                         pixel_stall,
    input  logic [rgbhsv_pkg::CHAN_W-1:0] red_in,
    input  logic [rgbhsv_pkg::CHAN_W-1:0] green_in,
    input  logic [rgbhsv_pkg::CHAN_W-1:0] blue_in,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [rgbhsv_pkg::HUE_W-1:0]  hue_out,
    output logic [rgbhsv_pkg::CHAN_W-1:0] saturation_out,
    output logic [rgbhsv_pkg::CHAN_W-1:0] value_out
);
    import rgbhsv_pkg::*;

    logic advance;

    // Stage A: max, min, delta and the signed channel difference.
    logic              a_valid_reg;
    max_sel_t          a_sel_reg, a_sel_next;
    logic              a_neg_reg, a_neg_next;
    logic [CHAN_W-1:0] a_mag_reg, a_mag_next;
    logic [CHAN_W-1:0] a_mx_reg, a_mx_next;
    logic [CHAN_W-1:0] a_delta_reg, a_delta_next;
    logic [CHAN_W-1:0] mn;
    logic [CHAN_W:0]   diff;

    // Stage B: dividends.
    logic      b_valid_reg;
    div_word_t b_reg, b_next;

    // Divider stages.
    logic [DIV_STAGES-1:0] div_valid_reg;
    div_word_t             div_reg [DIV_STAGES];
    div_word_t             div_last;

    // Output register.
    logic              result_valid_reg;
    logic [HUE_W-1:0]  hue_reg, hue_next;
    logic [CHAN_W-1:0] sat_reg;
    logic [CHAN_W-1:0] val_reg;
    logic [HUE_W-1:0]  quo;

    assign advance     = !result_valid_reg || !result_stall;
    assign pixel_stall = !advance;

    always_comb
    begin
        if (red_in >= green_in && red_in >= blue_in) begin
            a_sel_next = SEL_RED;
            a_mx_next  = red_in;
            diff       = {1'b0, green_in} - {1'b0, blue_in};
        end
        else if (green_in >= blue_in) begin
            a_sel_next = SEL_GREEN;
            a_mx_next  = green_in;
            diff       = {1'b0, blue_in} - {1'b0, red_in};
        end
        else begin
            a_sel_next = SEL_BLUE;
            a_mx_next  = blue_in;
            diff       = {1'b0, red_in} - {1'b0, green_in};
        end
        mn = red_in;
        if (green_in < mn) begin
            mn = green_in;
        end
        if (blue_in < mn) begin
            mn = blue_in;
        end
        a_delta_next = a_mx_next - mn;
        a_neg_next   = diff[CHAN_W];
        a_mag_next   = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
    end

    always_comb
    begin
        b_next       = '0;
        b_next.grey  = (a_delta_reg == '0);
        b_next.sel   = a_sel_reg;
        b_next.neg   = a_neg_reg;
        b_next.mx    = a_mx_reg;
        b_next.delta = a_delta_reg;
        // 3840 * mag = mag * 4096 - mag * 256, and 255 * delta = delta * 256 - delta.
        b_next.hrem  = (HUE_NUM_W'(a_mag_reg) << 12) - (HUE_NUM_W'(a_mag_reg) << 8);
        b_next.srem  = (SAT_NUM_W'(a_delta_reg) << 8) - SAT_NUM_W'(a_delta_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            div_valid_reg    <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (advance) begin
            a_valid_reg      <= pixel_valid;
            b_valid_reg      <= a_valid_reg;
            div_valid_reg    <= {div_valid_reg[DIV_STAGES-2:0], b_valid_reg};
            result_valid_reg <= div_valid_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            a_sel_reg   <= a_sel_next;
            a_neg_reg   <= a_neg_next;
            a_mag_reg   <= a_mag_next;
            a_mx_reg    <= a_mx_next;
            a_delta_reg <= a_delta_next;
            b_reg       <= b_next;
        end
    end

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        always_ff @(posedge clk)
        begin
            if (advance) begin
                if (s == 0) begin
                    div_reg[s] <= div_stage(b_reg, s);
                end
                else begin
                    div_reg[s] <= div_stage(div_reg[(s == 0) ? 0 : s - 1], s);
                end
            end
        end
    end

    assign div_last = div_reg[DIV_STAGES-1];
    assign quo      = HUE_W'(div_last.hquo);

    // Truncation toward zero: a negative quotient of zero is still zero.
    always_comb
    begin
        case (div_last.sel)
            SEL_GREEN: hue_next = div_last.neg ? HUE_GREEN_BASE - quo : HUE_GREEN_BASE + quo;
            SEL_BLUE:  hue_next = div_last.neg ? HUE_BLUE_BASE - quo : HUE_BLUE_BASE + quo;
            default:   hue_next = (div_last.neg && quo != '0) ? HUE_FULL - quo : quo;
        endcase
        if (div_last.grey) begin
            hue_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            hue_reg <= hue_next;
            sat_reg <= div_last.grey ? '0 : div_last.squo;
            val_reg <= div_last.mx;
        end
    end

    assign result_valid   = result_valid_reg;
    assign hue_out        = hue_reg;
    assign saturation_out = sat_reg;
    assign value_out      = val_reg;

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> hue_out < HUE_FULL)
        else $error("hue word out of range");

    a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && saturation_out == '0 |-> hue_out == '0)
        else $error("zero saturation with nonzero hue");

    a_black_sat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && value_out == '0 |-> saturation_out == '0)
        else $error("black pixel with nonzero saturation");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(div_valid_reg) && $stable(b_valid_reg) && $stable(a_valid_reg))
        else $error("pipeline moved during a stall");

endmodule
